// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define EAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define EAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/eas_pkg.sv =====
package eas_pkg;

    typedef logic [4:0] t_mode;
    typedef logic [1:0] t_kind;

    // Addressing modes
    localparam t_mode M_IMM8          = 5'd0;
    localparam t_mode M_IMM16         = 5'd1;
    localparam t_mode M_ZP            = 5'd2;
    localparam t_mode M_ZP_X          = 5'd3;
    localparam t_mode M_ZP_Y          = 5'd4;
    localparam t_mode M_ABS           = 5'd5;
    localparam t_mode M_ABS_X         = 5'd6;
    localparam t_mode M_ABS_Y         = 5'd7;
    localparam t_mode M_LONG          = 5'd8;
    localparam t_mode M_LONG_X        = 5'd9;
    localparam t_mode M_DP            = 5'd10;
    localparam t_mode M_DP_X          = 5'd11;
    localparam t_mode M_DP_Y          = 5'd12;
    localparam t_mode M_DP_X_IND      = 5'd13;
    localparam t_mode M_DP_IND        = 5'd14;
    localparam t_mode M_DP_IND_Y      = 5'd15;
    localparam t_mode M_DP_LONG_IND   = 5'd16;
    localparam t_mode M_DP_LONG_IND_Y = 5'd17;
    localparam t_mode M_ABS_IND       = 5'd18;
    localparam t_mode M_ABS_LONG_IND  = 5'd19;
    localparam t_mode M_SR            = 5'd20;
    localparam t_mode M_SR_IND_Y      = 5'd21;
    localparam t_mode M_REL8          = 5'd22;
    localparam t_mode M_REL16         = 5'd23;
    localparam t_mode M_BLOCK         = 5'd24;
    localparam t_mode NUM_MODES       = 5'd25;

    // Result kinds
    localparam t_kind K_READ  = 2'd0;
    localparam t_kind K_FINAL = 2'd1;
    localparam t_kind K_ERROR = 2'd2;

    // Commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef struct packed {
        logic        cmd;
        t_mode       mode;
        logic [15:0] start_pc;
        logic [15:0] index_x;
        logic [15:0] index_y;
        logic [15:0] stack_pointer;
        logic [7:0]  read_data;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] value;
        logic [15:0] pc_after;
    } t_result;

    typedef struct packed {
        logic        busy;
        t_mode       mode;
        logic [15:0] pc;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] sp;
        logic [2:0]  step;
        logic [23:0] accum;
        logic [15:0] ptr;
    } t_state;

    // Operand bytes fetched at PC
    function automatic logic [1:0] f_operand_bytes(input t_mode m);
        logic [1:0] n;
        unique case (m)
            M_IMM16, M_ABS, M_ABS_X, M_ABS_Y,
            M_ABS_IND, M_ABS_LONG_IND, M_REL16, M_BLOCK: n = 2'd2;
            M_LONG, M_LONG_X:                            n = 2'd3;
            M_IMM8, M_ZP, M_ZP_X, M_ZP_Y, M_DP, M_DP_X, M_DP_Y,
            M_DP_X_IND, M_DP_IND, M_DP_IND_Y, M_DP_LONG_IND,
            M_DP_LONG_IND_Y, M_SR, M_SR_IND_Y, M_REL8:   n = 2'd1;
            default:                                     n = 2'd0;
        endcase
        return n;
    endfunction

    // Pointer bytes fetched after the operand
    function automatic logic [1:0] f_pointer_bytes(input t_mode m);
        logic [1:0] n;
        unique case (m)
            M_DP_X_IND, M_DP_IND, M_DP_IND_Y,
            M_ABS_IND, M_SR_IND_Y:                      n = 2'd2;
            M_DP_LONG_IND, M_DP_LONG_IND_Y, M_ABS_LONG_IND: n = 2'd3;
            default:                                    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/eas_in_if.sv =====
interface eas_in_if import eas_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        cmd;
    t_mode       mode;
    logic [15:0] start_pc;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] stack_pointer;
    logic [7:0]  read_data;

    modport source (
        output valid, cmd, mode, start_pc, index_x, index_y, stack_pointer, read_data,
        input  ready
    );
    modport sink (
        input  valid, cmd, mode, start_pc, index_x, index_y, stack_pointer, read_data,
        output ready
    );
endinterface

// ===== rtl/core/eas_out_if.sv =====
interface eas_out_if import eas_pkg::*; ();
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [23:0] value;
    logic [15:0] pc_after;

    modport source (
        output valid, kind, value, pc_after,
        input  ready
    );
    modport sink (
        input  valid, kind, value, pc_after,
        output ready
    );
endinterface

// ===== rtl/core/eas_step.sv =====
module eas_step import eas_pkg::*; (
    input  t_item   i_item,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    logic [2:0]  k_next;
    logic [1:0]  ob;
    logic [1:0]  pb;
    logic [2:0]  ob3;
    logic [2:0]  obpb3;
    logic [1:0]  lane;
    logic [23:0] lane_bytes;
    logic [23:0] accum_new;
    logic [15:0] ptr_first;
    logic        first_ptr;
    logic [15:0] ptr_base;
    logic [2:0]  ptr_idx;
    logic [15:0] ptr_sum;
    logic [15:0] ptr_addr;
    logic [23:0] final_v;
    logic [7:0]  sum8;

    assign ob     = f_operand_bytes(i_state.mode);
    assign pb     = f_pointer_bytes(i_state.mode);
    assign ob3    = {1'b0, ob};
    assign obpb3  = {1'b0, ob} + {1'b0, pb};
    assign k_next = i_state.step + 3'd1;

    // operand bytes land by step, pointer bytes restart at lane zero
    assign lane = (i_state.step < ob3) ? i_state.step[1:0] : 2'(i_state.step - ob3);

    always_comb begin
        unique case (lane)
            2'd0:    lane_bytes = {16'h0000, i_item.read_data};
            2'd1:    lane_bytes = {8'h00, i_item.read_data, 8'h00};
            2'd2:    lane_bytes = {i_item.read_data, 16'h0000};
            default: lane_bytes = 24'h000000;
        endcase
    end

    assign accum_new = i_state.accum | lane_bytes;

    // pointer formed from the operand
    always_comb begin
        unique case (i_state.mode)
            M_DP_X_IND:                ptr_first = {8'h00, 8'(accum_new[7:0] + i_state.x[7:0])};
            M_ABS_IND, M_ABS_LONG_IND: ptr_first = accum_new[15:0];
            M_SR_IND_Y:                ptr_first = i_state.sp + accum_new[15:0];
            default:                   ptr_first = {8'h00, accum_new[7:0]};
        endcase
    end

    assign first_ptr = (k_next == ob3);
    assign ptr_base  = first_ptr ? ptr_first : i_state.ptr;
    assign ptr_idx   = first_ptr ? 3'd0 : 3'(k_next - ob3);
    assign ptr_sum   = ptr_base + {13'd0, ptr_idx};
    // direct page pointers wrap inside page zero
    assign ptr_addr  = (i_state.mode >= M_DP_X_IND && i_state.mode <= M_DP_LONG_IND_Y)
                     ? {8'h00, ptr_sum[7:0]} : ptr_sum;

    always_comb begin
        sum8 = 8'h00;
        unique case (i_state.mode)
            M_ZP_X, M_DP_X: begin
                sum8    = accum_new[7:0] + i_state.x[7:0];
                final_v = {16'h0000, sum8};
            end
            M_ZP_Y, M_DP_Y: begin
                sum8    = accum_new[7:0] + i_state.y[7:0];
                final_v = {16'h0000, sum8};
            end
            M_ABS_X:                         final_v = {8'h00, 16'(accum_new[15:0] + i_state.x)};
            M_ABS_Y, M_DP_IND_Y, M_SR_IND_Y: final_v = {8'h00, 16'(accum_new[15:0] + i_state.y)};
            M_LONG_X:        final_v = accum_new + {8'h00, i_state.x};
            M_DP_LONG_IND_Y: final_v = accum_new + {8'h00, i_state.y};
            M_SR:            final_v = {8'h00, 16'(i_state.sp + accum_new[15:0])};
            M_REL8:          final_v = {8'h00, {8{accum_new[7]}}, accum_new[7:0]};
            default:         final_v = accum_new;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{kind: K_ERROR, value: 24'h000000, pc_after: 16'h0000};
        if (i_item.cmd == CMD_START) begin
            if (i_state.busy || i_item.mode >= NUM_MODES) begin
                o_state.busy = 1'b0;
            end else begin
                o_state.busy     = 1'b1;
                o_state.mode     = i_item.mode;
                o_state.pc       = i_item.start_pc + 16'd1;
                o_state.x        = i_item.index_x;
                o_state.y        = i_item.index_y;
                o_state.sp       = i_item.stack_pointer;
                o_state.step     = 3'd0;
                o_state.accum    = 24'h000000;
                o_state.ptr      = 16'h0000;
                o_result.kind     = K_READ;
                o_result.value    = {8'h00, i_item.start_pc};
                o_result.pc_after = i_item.start_pc + 16'd1;
            end
        end else if (i_state.busy) begin
            o_state.step  = k_next;
            o_state.accum = accum_new;
            if (k_next < ob3) begin
                o_state.pc        = i_state.pc + 16'd1;
                o_result.kind     = K_READ;
                o_result.value    = {8'h00, i_state.pc};
                o_result.pc_after = i_state.pc + 16'd1;
            end else if (k_next < obpb3) begin
                if (first_ptr) begin
                    o_state.ptr   = ptr_first;
                    o_state.accum = 24'h000000;
                end
                o_result.kind     = K_READ;
                o_result.value    = {8'h00, ptr_addr};
                o_result.pc_after = i_state.pc;
            end else begin
                o_state.busy      = 1'b0;
                o_result.kind     = K_FINAL;
                o_result.value    = final_v;
                o_result.pc_after = i_state.pc;
            end
        end
    end

endmodule

// ===== rtl/core/eas_out_reg.sv =====
module eas_out_reg import eas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_result          i_result,
    output logic             o_can_push,
    eas_out_if.source        o_rsp
);

    logic    r_valid;
    t_result r_data;

    assign o_can_push = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_result;
        end
    end

    assign o_rsp.valid    = r_valid;
    assign o_rsp.kind     = r_data.kind;
    assign o_rsp.value    = r_data.value;
    assign o_rsp.pc_after = r_data.pc_after;

endmodule

// ===== rtl/core/cpu_effective_address_sequencer.sv =====
// Effective address sequencer for a 16-bit CPU with a 24-bit address space.
// Input channel i_req carries one transaction per step: a start transaction
// (cmd = start) with mode, PC, X, Y and stack pointer, or a data transaction
// (cmd = data) carrying the byte returned for the last bus read request.
// Output channel o_rsp answers every input transaction with exactly one
// transaction: a bus read request (address in value), the final value or
// address with the advanced PC, or a sequencing error.
// The response is registered on the edge that accepts the input. Throughput
// is one transaction per cycle while o_rsp.ready is high, set by the single
// output register; the step logic is one pass of small adds and byte merges.
// A new input is taken while the current response is being taken.
// If the receiver stalls, the response register holds and i_req.ready drops
// until it drains; nothing is lost.
// Reset (synchronous, active low) leaves the block idle with no response
// pending; i_req.ready is low during reset.
`include "assert_macros.svh"

module cpu_effective_address_sequencer import eas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eas_in_if.sink    i_req,
    eas_out_if.source o_rsp
);

    t_state  r_state;
    t_state  n_state;
    t_item   w_item;
    t_result w_result;
    logic    w_can_push;
    logic    w_accept;

    assign w_item = '{
        cmd:           i_req.cmd,
        mode:          i_req.mode,
        start_pc:      i_req.start_pc,
        index_x:       i_req.index_x,
        index_y:       i_req.index_y,
        stack_pointer: i_req.stack_pointer,
        read_data:     i_req.read_data
    };

    // take input whenever the response slot is free or draining
    assign i_req.ready = i_rst_n && w_can_push;
    assign w_accept    = i_req.valid && i_req.ready;

    // next state and response for the presented transaction
    eas_step u_step (
        .i_item   (w_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // sequencer state only moves on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    eas_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_result   (w_result),
        .o_can_push (w_can_push),
        .o_rsp      (o_rsp)
    );

    // every accepted transaction shows up as a response next cycle
    `EAS_ASSERT(a_resp_follows, i_clk, i_rst_n, w_accept |=> o_rsp.valid, "missing response")
    // start while busy drops the running sequence
    `EAS_ASSERT(a_start_busy_drop, i_clk, i_rst_n,
        w_accept && w_item.cmd == CMD_START && r_state.busy |=> !r_state.busy,
        "busy start did not abort")
    // data while idle leaves state untouched
    `EAS_ASSERT(a_idle_data_hold, i_clk, i_rst_n,
        w_accept && w_item.cmd == CMD_DATA && !r_state.busy |=> $stable(r_state),
        "idle data changed state")
    // no sequence runs past five bytes
    `EAS_ASSERT(a_step_bound, i_clk, i_rst_n, r_state.busy |-> r_state.step <= 3'd4,
        "step count out of range")

endmodule
